[rtl/first_fit_heap_allocator_unit_defines.svh]
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define FFHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ffha_pkg.sv]
`default_nettype none

package ffha_pkg;

  localparam int unsigned HEAP_BYTES    = 65536;
  localparam int unsigned GRANULE_BYTES = 16;
  localparam int unsigned HEADER_BYTES  = 20;
  localparam int unsigned NUM_GRANULES  = HEAP_BYTES / GRANULE_BYTES;
  localparam int unsigned GRAN_SHIFT    = $clog2(GRANULE_BYTES);
  localparam int unsigned IDX_W         = $clog2(NUM_GRANULES);
  localparam int unsigned SIZE_W        = IDX_W + 1;
  localparam int unsigned REQ_W         = 17;
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned NEED_W        = REQ_W + 1 - GRAN_SHIFT;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_LOAD,
    S_A_WALK,
    S_A_SPLIT,
    S_A_LINK,
    S_A_MARK,
    S_F_LOAD,
    S_F_BLOCK,
    S_F_NEXT,
    S_F_PRED,
    S_F_PREV,
    S_DONE
  } state_t;

  function automatic logic [NEED_W-1:0] need_granules(logic [REQ_W-1:0] req);
    logic [REQ_W:0]    sum;
    logic [NEED_W-1:0] n;
    sum = {1'b0, req} + (REQ_W+1)'(HEADER_BYTES + GRANULE_BYTES - 1);
    n = NEED_W'(sum >> GRAN_SHIFT);
    if (n == '0) begin
      n = NEED_W'(1);
    end
    return n;
  endfunction

  function automatic logic [SIZE_W-1:0] step_end(logic [IDX_W-1:0] base,
                                                 logic [SIZE_W-1:0] size);
    logic [SIZE_W:0] s;
    logic [SIZE_W:0] sum;
    s = (size == '0) ? (SIZE_W+1)'(1) : {1'b0, size};
    sum = (SIZE_W+1)'(base) + s;
    return (sum > (SIZE_W+1)'(NUM_GRANULES)) ? SIZE_W'(NUM_GRANULES) : sum[SIZE_W-1:0];
  endfunction

  function automatic logic [SIZE_W-1:0] capped_sum(logic [IDX_W-1:0] base,
                                                   logic [SIZE_W-1:0] a,
                                                   logic [SIZE_W-1:0] b);
    logic [SIZE_W:0]   sum;
    logic [SIZE_W-1:0] lim;
    sum = (SIZE_W+1)'(a) + (SIZE_W+1)'(b);
    lim = SIZE_W'(NUM_GRANULES) - SIZE_W'(base);
    return (sum > (SIZE_W+1)'(lim)) ? lim : sum[SIZE_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ffha_ram.sv]
`default_nettype none

module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator_unit.sv]
// First-fit heap allocator with coalescing over a 64 KiB arena of 16-byte
// granules; block sizes, used flags and back links sit in three 4096-entry RAMs
// indexed by block start. One request at a time: in_ready is high only when
// idle. An allocate walks the blocks first-fit, reading one block per cycle
// from the single read port, and splits the block that fits when it can. A
// free of an address below the header goes straight to the result. Results
// wait in an output register, so a new request is accepted while the previous
// result still waits to be taken; a request finishes only once the result
// before it has been handed over. After reset the block writes the initial
// whole-heap block before it accepts a request.

`default_nettype none

`include "first_fit_heap_allocator_unit_defines.svh"

module first_fit_heap_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [16:0] request_bytes,
  input  wire logic [15:0] payload_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [15:0] result_address,
  output logic             ok
);

  localparam int unsigned IDX_W  = ffha_pkg::IDX_W;
  localparam int unsigned SIZE_W = ffha_pkg::SIZE_W;
  localparam int unsigned NEED_W = ffha_pkg::NEED_W;
  localparam int unsigned ADDR_W = ffha_pkg::ADDR_W;

  ffha_pkg::state_t state, state_next;

  logic [IDX_W-1:0]  g, g_next;
  logic [IDX_W-1:0]  p, p_next;
  logic [SIZE_W-1:0] size, size_next;
  logic [SIZE_W-1:0] nx, nx_next;
  logic [NEED_W-1:0] need, need_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  logic              res_ok, res_ok_next;
  logic              out_valid_next;
  logic [ADDR_W-1:0] result_address_next;
  logic              ok_next;

  logic [IDX_W-1:0]  raddr;
  logic [SIZE_W-1:0] gran_rd;
  logic              use_rd;
  logic [IDX_W-1:0]  prev_rd;
  logic              gran_we, use_we, prev_we;
  logic [IDX_W-1:0]  gran_wa, use_wa, prev_wa;
  logic [SIZE_W-1:0] gran_wd;
  logic              use_wd;
  logic [IDX_W-1:0]  prev_wd;

  logic [IDX_W-1:0]  step_base;
  logic [SIZE_W-1:0] step_size;
  logic [SIZE_W-1:0] step_end;
  logic              step_in_heap;
  logic [IDX_W-1:0]  cap_base;
  logic [SIZE_W-1:0] merged;
  logic              fit;
  logic              can_split;
  logic [IDX_W-1:0]  tail;
  logic [ADDR_W-1:0] free_off;
  logic [ADDR_W-1:0] free_idx;

  ffha_ram #(.WIDTH(SIZE_W), .DEPTH(ffha_pkg::NUM_GRANULES)) u_gran_ram (
    .clk   (clk),
    .we    (gran_we),
    .waddr (gran_wa),
    .wdata (gran_wd),
    .raddr (raddr),
    .rdata (gran_rd)
  );

  ffha_ram #(.WIDTH(1), .DEPTH(ffha_pkg::NUM_GRANULES)) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_wa),
    .wdata (use_wd),
    .raddr (raddr),
    .rdata (use_rd)
  );

  ffha_ram #(.WIDTH(IDX_W), .DEPTH(ffha_pkg::NUM_GRANULES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (raddr),
    .rdata (prev_rd)
  );

  // Shared block-step and merge arithmetic.
  assign cap_base  = (state == ffha_pkg::S_F_PREV) ? p : g;
  assign merged    = ffha_pkg::capped_sum(cap_base, size, gran_rd);
  assign step_base = cap_base;
  assign step_size = (state == ffha_pkg::S_F_NEXT || state == ffha_pkg::S_F_PREV) ?
                     merged : gran_rd;
  assign step_end     = ffha_pkg::step_end(step_base, step_size);
  assign step_in_heap = step_end < SIZE_W'(ffha_pkg::NUM_GRANULES);

  assign fit       = !use_rd && (NEED_W'(gran_rd) >= need);
  assign can_split = (NEED_W'(gran_rd) > need) &&
                     ((NEED_W+1)'(g) + (NEED_W+1)'(need) <
                      (NEED_W+1)'(ffha_pkg::NUM_GRANULES));
  assign tail      = g + need[IDX_W-1:0];

  assign free_off = payload_address - ADDR_W'(ffha_pkg::HEADER_BYTES);
  assign free_idx = free_off >> ffha_pkg::GRAN_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    g              <= g_next;
    p              <= p_next;
    size           <= size_next;
    nx             <= nx_next;
    need           <= need_next;
    res_addr       <= res_addr_next;
    res_ok         <= res_ok_next;
    result_address <= result_address_next;
    ok             <= ok_next;
  end

  always_comb begin
    state_next          = state;
    g_next              = g;
    p_next              = p;
    size_next           = size;
    nx_next             = nx;
    need_next           = need;
    res_addr_next       = res_addr;
    res_ok_next         = res_ok;
    out_valid_next      = out_valid && !out_ready;
    result_address_next = result_address;
    ok_next             = ok;
    in_ready            = 1'b0;
    raddr               = g;
    gran_we             = 1'b0;
    gran_wa             = g;
    gran_wd             = size;
    use_we              = 1'b0;
    use_wa              = g;
    use_wd              = 1'b0;
    prev_we             = 1'b0;
    prev_wa             = g;
    prev_wd             = g;

    unique case (state)
      ffha_pkg::S_INIT: begin
        gran_we    = 1'b1;
        gran_wa    = '0;
        gran_wd    = SIZE_W'(ffha_pkg::NUM_GRANULES);
        use_we     = 1'b1;
        use_wa     = '0;
        prev_we    = 1'b1;
        prev_wa    = '0;
        prev_wd    = '0;
        state_next = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_addr_next = '0;
          res_ok_next   = 1'b1;
          if (func == ffha_pkg::FUNC_FREE) begin
            if (payload_address < ADDR_W'(ffha_pkg::HEADER_BYTES) ||
                free_idx >= ADDR_W'(ffha_pkg::NUM_GRANULES)) begin
              state_next = ffha_pkg::S_DONE;
            end else begin
              g_next     = free_idx[IDX_W-1:0];
              state_next = ffha_pkg::S_F_LOAD;
            end
          end else begin
            need_next  = ffha_pkg::need_granules(request_bytes);
            g_next     = '0;
            state_next = ffha_pkg::S_A_LOAD;
          end
        end
      end
      ffha_pkg::S_A_LOAD: begin
        state_next = ffha_pkg::S_A_WALK;
      end
      ffha_pkg::S_A_WALK: begin
        if (fit) begin
          size_next     = gran_rd;
          nx_next       = step_end;
          res_addr_next = {g, {ffha_pkg::GRAN_SHIFT{1'b0}}} +
                          ADDR_W'(ffha_pkg::HEADER_BYTES);
          state_next    = can_split ? ffha_pkg::S_A_SPLIT : ffha_pkg::S_A_MARK;
        end else if (!step_in_heap) begin
          res_ok_next = 1'b0;
          state_next  = ffha_pkg::S_DONE;
        end else begin
          g_next = step_end[IDX_W-1:0];
          raddr  = step_end[IDX_W-1:0];
        end
      end
      ffha_pkg::S_A_SPLIT: begin
        gran_we    = 1'b1;
        gran_wa    = tail;
        gran_wd    = size - need[SIZE_W-1:0];
        use_we     = 1'b1;
        use_wa     = tail;
        use_wd     = 1'b0;
        prev_we    = 1'b1;
        prev_wa    = tail;
        prev_wd    = g;
        state_next = ffha_pkg::S_A_LINK;
      end
      ffha_pkg::S_A_LINK: begin
        gran_we    = 1'b1;
        gran_wd    = need[SIZE_W-1:0];
        use_we     = 1'b1;
        use_wd     = 1'b1;
        prev_we    = nx < SIZE_W'(ffha_pkg::NUM_GRANULES);
        prev_wa    = nx[IDX_W-1:0];
        prev_wd    = tail;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_A_MARK: begin
        use_we     = 1'b1;
        use_wd     = 1'b1;
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_F_LOAD: begin
        state_next = ffha_pkg::S_F_BLOCK;
      end
      ffha_pkg::S_F_BLOCK: begin
        use_we    = 1'b1;
        use_wd    = 1'b0;
        size_next = gran_rd;
        p_next    = prev_rd;
        nx_next   = step_end;
        if (step_in_heap) begin
          raddr      = step_end[IDX_W-1:0];
          state_next = ffha_pkg::S_F_NEXT;
        end else begin
          state_next = ffha_pkg::S_F_PRED;
        end
      end
      ffha_pkg::S_F_NEXT: begin
        if (!use_rd) begin
          gran_we   = 1'b1;
          gran_wd   = merged;
          size_next = merged;
          prev_we   = step_in_heap;
          prev_wa   = step_end[IDX_W-1:0];
          prev_wd   = g;
        end
        state_next = ffha_pkg::S_F_PRED;
      end
      ffha_pkg::S_F_PRED: begin
        if (g == '0 || p >= g) begin
          state_next = ffha_pkg::S_DONE;
        end else begin
          raddr      = p;
          state_next = ffha_pkg::S_F_PREV;
        end
      end
      ffha_pkg::S_F_PREV: begin
        if (!use_rd &&
            ((SIZE_W+1)'(p) + (SIZE_W+1)'(gran_rd) == (SIZE_W+1)'(g))) begin
          gran_we = 1'b1;
          gran_wa = p;
          gran_wd = merged;
          prev_we = step_in_heap;
          prev_wa = step_end[IDX_W-1:0];
          prev_wd = p;
        end
        state_next = ffha_pkg::S_DONE;
      end
      ffha_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          result_address_next = res_addr;
          ok_next             = res_ok;
          state_next          = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffha_pkg::S_IDLE;
      end
    endcase
  end

  `FFHA_ASSERT_SAME(a_fail_zero, out_valid && !ok, result_address == '0, "failed allocate with nonzero address")
  `FFHA_ASSERT_SAME(a_walk_forward, state == ffha_pkg::S_A_WALK && $past(state) == ffha_pkg::S_A_WALK, g > $past(g), "block walk did not advance")
  `FFHA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "request accepted while busy")
  `FFHA_ASSERT_SAME(a_link_forward, prev_we && state == ffha_pkg::S_F_PREV, prev_wa > p, "back link written behind merged block")

endmodule

`default_nettype wire
